// ----- hw/rtl/htca_pkg.sv -----
// ----------------------------------------------------------------------------
// htca_pkg
// Shared types and constants of the hit to circle track assignment block.
// ----------------------------------------------------------------------------
`default_nettype none
package htca_pkg;
    localparam int MAX_TRACKS_DEF = 16;
    localparam int COORD_W        = 24;
    localparam int DRIFT_W        = 12;
    localparam int SLOT_W         = 4;
    localparam int COUNT_W        = 5;
    localparam int CELL_STAGES    = 3;
    localparam logic [COORD_W-1:0] DIST_MAX = 24'hFFFFFF;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_HIT  = 1'b1;

    // one hit travelling down the cell row
    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] wire_x;
        logic signed [COORD_W-1:0] wire_y;
        logic [DRIFT_W-1:0]        drift;
        logic [DRIFT_W:0]          tol;     // 2 * sigma
        logic                      found;
        logic [SLOT_W-1:0]         slot;
    } t_flow;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [COORD_W-1:0]        radius;
    } t_track;
endpackage
`default_nettype wire

// ----- hw/rtl/hit_to_circle_track_assign.sv -----
// ----------------------------------------------------------------------------
// hit_to_circle_track_assign
// Assigns drift chamber hits to the first circular track candidate in range.
// ----------------------------------------------------------------------------
// A row of MAX_TRACKS cells, one per track slot, each holding its circle.
// A hit beat enters the row every cycle unless the output stalls, and steps
// through 3 register stages per cell (difference, squares, compare) on its
// way to the output register. The test is exact: every comparison is done
// on squared integers. A load beat (tuser = 0) writes one slot and returns
// nothing; it is taken only once no hit is in the row, so it waits behind
// earlier hits until they have left the row. The output register holds a
// finished result while new hits keep flowing as long as the downstream
// side takes beats; a stalled output freezes the whole row.
`default_nettype none
module hit_to_circle_track_assign #(
    parameter int MAX_TRACKS = htca_pkg::MAX_TRACKS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [4:0]   i_cfg_wdata,   // track_count
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // entry_index[3:0] center_x[27:4] center_y[51:28] circle_radius[75:52]
    // wire_x[99:76] wire_y[123:100] drift_length[135:124] drift_sigma[147:136]
    input  wire logic [151:0] i_s_tdata,
    input  wire logic         i_s_tuser,     // cmd
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [7:0]        o_m_tdata,     // chosen_track[3:0]
    output logic              o_m_tuser      // assigned
);
    localparam int DEPTH = htca_pkg::CELL_STAGES * MAX_TRACKS;
    localparam int CNT_W = $clog2(DEPTH + 2);

    logic [htca_pkg::COUNT_W-1:0] r_count;
    logic [CNT_W-1:0]             r_inflight;
    logic                         w_adv, w_acc, w_acc_hit, w_acc_load, w_end_pop;
    htca_pkg::t_flow              w_link [MAX_TRACKS+1];
    htca_pkg::t_track             w_load;

    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv && (i_s_tuser == htca_pkg::CMD_HIT || r_inflight == '0);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_acc_hit  = w_acc && i_s_tuser == htca_pkg::CMD_HIT;
    assign w_acc_load = w_acc && i_s_tuser == htca_pkg::CMD_LOAD;
    assign w_end_pop  = w_adv && w_link[MAX_TRACKS].valid;

    always_comb begin
        w_load.center_x = i_s_tdata[27:4];
        w_load.center_y = i_s_tdata[51:28];
        w_load.radius   = i_s_tdata[75:52];
        w_link[0].valid  = w_acc_hit;
        w_link[0].wire_x = i_s_tdata[99:76];
        w_link[0].wire_y = i_s_tdata[123:100];
        w_link[0].drift  = i_s_tdata[135:124];
        w_link[0].tol    = {i_s_tdata[147:136], 1'b0};
        w_link[0].found  = 1'b0;
        w_link[0].slot   = '0;
    end

    for (genvar g = 0; g < MAX_TRACKS; g++) begin : g_cell
        htca_cell #(.IDX(g)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_adv),
            .i_load_we (w_acc_load && 9'(i_s_tdata[3:0]) == 9'(g)),
            .i_load    (w_load),
            .i_count   (r_count),
            .i_flow    (w_link[g]),
            .o_flow    (w_link[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_inflight <= '0;
            o_m_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            r_inflight <= r_inflight + CNT_W'(w_acc_hit) - CNT_W'(w_end_pop);
            if (w_adv) begin
                o_m_tvalid <= w_link[MAX_TRACKS].valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end_pop) begin
            o_m_tuser <= w_link[MAX_TRACKS].found;
            o_m_tdata <= {4'b0, w_link[MAX_TRACKS].found ? w_link[MAX_TRACKS].slot : 4'b0};
        end
    end

    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_load |-> r_inflight == '0) else $error("load taken with hits in flight");
    a_end_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[MAX_TRACKS].valid |-> r_inflight != '0) else $error("untracked hit at row end");
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(DEPTH)) else $error("in-flight count overflow");
    a_unassigned_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> o_m_tdata == '0) else $error("slot set without match");
endmodule
`default_nettype wire

// ----- hw/rtl/htca_cell.sv -----
// ----------------------------------------------------------------------------
// htca_cell
// One track slot: holds its circle and tests each passing hit in 3 stages.
// ----------------------------------------------------------------------------
`default_nettype none
module htca_cell #(
    parameter int IDX = 0
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic                          i_load_we,
    input  wire htca_pkg::t_track              i_load,
    input  wire logic [htca_pkg::COUNT_W-1:0]  i_count,
    input  wire htca_pkg::t_flow               i_flow,
    output htca_pkg::t_flow                    o_flow
);
    localparam logic [8:0] CELL_ID = 9'(IDX);
    localparam logic signed [25:0] DMAX_S = 26'($unsigned(htca_pkg::DIST_MAX));
    localparam logic [49:0] DMAX_SQ = 50'(htca_pkg::DIST_MAX) * 50'(htca_pkg::DIST_MAX);

    htca_pkg::t_track r_trk;
    htca_pkg::t_flow  r_fa, r_fb, r_fc;
    htca_pkg::t_flow  w_fc;

    // stage A
    logic [24:0]        r_ax, r_ay;
    logic signed [25:0] r_v [4];   // r-hi, r+hi, r+lo, r-lo
    logic               r_hi_zero, r_lo_neg;
    // stage B
    logic [49:0]        r_sqx, r_sqy;
    logic [49:0]        r_vsq [4];
    logic [3:0]         r_neg, r_zero, r_gt, r_lt;
    logic               r_hi_zero_b, r_lo_neg_b;

    logic signed [24:0] w_dx, w_dy;
    logic [13:0]        w_hi;
    logic signed [25:0] w_lo, w_r;
    logic [49:0]        w_sq;
    logic               w_sat, w_under, w_over, w_match, w_active;
    logic [3:0]         w_below, w_above;

    always_comb begin
        w_dx = {r_trk.center_x[23], r_trk.center_x} - {i_flow.wire_x[23], i_flow.wire_x};
        w_dy = {r_trk.center_y[23], r_trk.center_y} - {i_flow.wire_y[23], i_flow.wire_y};
        w_hi = 14'(i_flow.drift) + 14'(i_flow.tol);
        w_lo = 26'(i_flow.drift) - 26'(i_flow.tol);
        w_r  = 26'(r_trk.radius);
    end

    always_comb begin
        w_sq  = r_sqx + r_sqy;
        w_sat = w_sq > DMAX_SQ;
        for (int k = 0; k < 4; k++) begin
            w_below[k] = !(r_neg[k] || r_zero[k]) && (w_sat ? r_gt[k] : (w_sq < r_vsq[k]));
            w_above[k] = r_neg[k] || (w_sat ? r_lt[k] : (w_sq > r_vsq[k]));
        end
        w_under  = !r_hi_zero_b && w_above[0] && w_below[1];
        w_over   = r_lo_neg_b || w_above[2] || w_below[3];
        w_active = CELL_ID < 9'(i_count);
        w_match  = w_under && w_over && w_active;
    end

    // first match along the row wins
    always_comb begin
        w_fc = r_fb;
        if (!r_fb.found && w_match) begin
            w_fc.found = 1'b1;
            w_fc.slot  = 4'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_we) begin
            r_trk <= i_load;
        end
        if (i_adv) begin
            r_ax      <= w_dx[24] ? 25'(-w_dx) : 25'(w_dx);
            r_ay      <= w_dy[24] ? 25'(-w_dy) : 25'(w_dy);
            r_v[0]    <= w_r - 26'(w_hi);
            r_v[1]    <= w_r + 26'(w_hi);
            r_v[2]    <= w_r + w_lo;
            r_v[3]    <= w_r - w_lo;
            r_hi_zero <= w_hi == '0;
            r_lo_neg  <= w_lo[25];
            r_sqx     <= 50'(r_ax) * 50'(r_ax);
            r_sqy     <= 50'(r_ay) * 50'(r_ay);
            for (int k = 0; k < 4; k++) begin
                r_vsq[k]  <= 50'(r_v[k][24:0]) * 50'(r_v[k][24:0]);
                r_neg[k]  <= r_v[k][25];
                r_zero[k] <= r_v[k] == '0;
                r_gt[k]   <= r_v[k] > DMAX_S;
                r_lt[k]   <= r_v[k] < DMAX_S;
            end
            r_hi_zero_b <= r_hi_zero;
            r_lo_neg_b  <= r_lo_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa.valid <= 1'b0;
            r_fb.valid <= 1'b0;
            r_fc.valid <= 1'b0;
        end else if (i_adv) begin
            r_fa <= i_flow;
            r_fb <= r_fa;
            r_fc <= w_fc;
        end
    end

    assign o_flow = r_fc;
endmodule
`default_nettype wire
